FILE: hdl/rplw_pkg.sv
package rplw_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int HALF_SIZE  = 2048;

    localparam int RADIUS_W = 18;
    localparam int WEIGHT_W = 21;
    localparam int INV_W    = 24;
    localparam int FX_W     = 11;
    localparam int FY_W     = 12;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // one table entry: weight above radius
    localparam int ENTRY_W = RADIUS_W + WEIGHT_W;

    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

    localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [1:0] CFG_INV_X       = 2'd1;
    localparam logic [1:0] CFG_INV_Y       = 2'd2;

    localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // s_tdata: slot, brk_radius, brk_weight, freq_x, freq_y
    localparam int S_DATA_BITS = SLOT_W + RADIUS_W + WEIGHT_W + FX_W + FY_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    // m_tdata: weight, radius, status
    localparam int M_DATA_BITS = WEIGHT_W + RADIUS_W + STATUS_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

endpackage

FILE: hdl/rplw_ram.sv
module rplw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/radial_piecewise_linear_weight_core.sv
// Radial piecewise-linear weighting of Fourier pixels.
// Input channel s_*: load items (tuser = 0) write one breakpoint (radius,
// weight) into the table at slot; query items (tuser = 1) give a pixel
// coordinate. Each item yields exactly one result on m_*: weight, radius
// and status (0 valid, 1 load done, 2 table radii decreasing).
// Configuration writes (cfg_*) set point count and the two inverse extents;
// they are taken at any time but must happen while the block is idle.
// A load result is valid the cycle after accept. A query result passes
// through multiply, square, square root (one result bit a cycle), table
// walk (through the single memory read port, one entry a cycle) and
// select; when the weight is interpolated, product and restoring division
// (one quotient bit a cycle) follow. The table memory, the bit-serial
// root and the divider set the query timing.
// One item is worked on at a time; s_tready is low from accept until the
// result has left the output register, so a stalled receiver holds the
// result and blocks the next item.
// Reset clears control state and sets point count to 1, extents to 0. The
// table has no reset: querying an unwritten entry is not allowed.
module radial_piecewise_linear_weight_core
    import rplw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot, brk_radius, brk_weight, freq_x, freq_y (lowest first), zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    // kind
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // weight, radius, status (lowest first), zero pad
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [INV_W-1:0]     cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_INTP  = 4'd5;
    localparam logic [3:0] S_MULW  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam int AX_W   = 35;  // 11 or 12 bits times 24 bits
    localparam int SUM_W  = 53;
    localparam int ROOT_W = 27;
    localparam int DIFF_W = RADIUS_W + 1;
    localparam int PROD_W = WEIGHT_W + RADIUS_W + 1;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int RCNT_W = $clog2(ROOT_W + 1);

    // ---------------- input unpack
    logic [SLOT_W-1:0]          in_slot;
    logic [RADIUS_W-1:0]        in_brk_radius;
    logic signed [WEIGHT_W-1:0] in_brk_weight;
    logic [FX_W-1:0]            in_freq_x;
    logic signed [FY_W-1:0]     in_freq_y;

    assign in_slot       = s_tdata[SLOT_W-1:0];
    assign in_brk_radius = s_tdata[SLOT_W +: RADIUS_W];
    assign in_brk_weight = s_tdata[SLOT_W+RADIUS_W +: WEIGHT_W];
    assign in_freq_x     = s_tdata[SLOT_W+RADIUS_W+WEIGHT_W +: FX_W];
    assign in_freq_y     = s_tdata[SLOT_W+RADIUS_W+WEIGHT_W+FX_W +: FY_W];

    // ---------------- configuration
    logic [CNT_W-1:0] point_count_reg;
    logic [INV_W-1:0] inv_x_reg;
    logic [INV_W-1:0] inv_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= CNT_W'(1);
            inv_x_reg       <= '0;
            inv_y_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POINT_COUNT: point_count_reg <= cfg_data[CNT_W-1:0];
                CFG_INV_X:       inv_x_reg <= cfg_data;
                CFG_INV_Y:       inv_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective point count 1..MAX_POINTS
    logic [CNT_W-1:0] n_eff;
    always_comb begin
        if (point_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (point_count_reg > CNT_W'(MAX_POINTS)) begin
            n_eff = CNT_W'(MAX_POINTS);
        end else begin
            n_eff = point_count_reg;
        end
    end

    // ---------------- state and datapath registers
    logic [3:0]                 state_reg;
    logic                       s_ready_reg;
    logic                       m_valid_reg;
    logic [FX_W-1:0]            fx_reg;
    logic [FY_W-1:0]            my_reg;     // magnitude of saturated freq_y
    logic [AX_W-1:0]            ax_reg;
    logic [AX_W-1:0]            ay_reg;
    logic [SUM_W-1:0]           rem_reg;    // root remainder
    logic [ROOT_W-1:0]          root_reg;
    logic [RCNT_W-1:0]          rcnt_reg;
    logic                       sat_reg;
    logic [RADIUS_W-1:0]        r_reg;
    logic [CNT_W-1:0]           idx_reg;    // entry being received
    logic                       bad_reg;
    logic                       hit_reg;
    logic [RADIUS_W-1:0]        prev_r_reg;
    logic signed [WEIGHT_W-1:0] prev_w_reg;
    logic [RADIUS_W-1:0]        first_r_reg;
    logic [RADIUS_W-1:0]        last_r_reg;
    logic signed [WEIGHT_W-1:0] last_w_reg;
    logic [RADIUS_W-1:0]        r0_reg;
    logic [RADIUS_W-1:0]        r1_reg;
    logic signed [WEIGHT_W-1:0] w0_reg;
    logic signed [WEIGHT_W-1:0] w1_reg;
    logic signed [PROD_W-1:0]   p0_reg;
    logic signed [PROD_W-1:0]   p1_reg;
    logic                       neg_reg;
    logic [NUM_W-1:0]           num_reg;    // dividend shifting into quotient
    logic [DIFF_W-1:0]          dvr_reg;
    logic [DIFF_W:0]            drem_reg;
    logic [DCNT_W-1:0]          dcnt_reg;
    logic signed [WEIGHT_W-1:0] wout_reg;
    logic [STATUS_W-1:0]        stat_reg;

    // ---------------- table memory
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]     raddr_cnt_reg;

    assign ram_we    = s_tvalid && s_tready && (s_tuser == KIND_LOAD)
                       && ({1'b0, in_slot} < CNT_W'(MAX_POINTS));
    assign ram_raddr = raddr_cnt_reg[ADDR_W-1:0];

    rplw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_slot[ADDR_W-1:0]),
        .wdata ({in_brk_weight, in_brk_radius}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [RADIUS_W-1:0]        rd_r;
    logic signed [WEIGHT_W-1:0] rd_w;
    assign rd_r = ram_rdata[RADIUS_W-1:0];
    assign rd_w = ram_rdata[ENTRY_W-1:RADIUS_W];

    // ---------------- square root step
    logic [SUM_W-1:0] rt_trial;
    logic             rt_ge;
    logic [SUM_W-1:0] rt_bit;
    always_comb begin
        rt_bit   = SUM_W'(1) << (2 * (rcnt_reg - RCNT_W'(1)));
        rt_trial = ({{(SUM_W-ROOT_W){1'b0}}, root_reg} << rcnt_reg) + rt_bit;
        rt_ge    = rem_reg >= rt_trial;
    end

    // ---------------- division step
    logic [DIFF_W:0] dv_shift;
    logic            dv_ge;
    always_comb begin
        dv_shift = {drem_reg[DIFF_W-1:0], num_reg[NUM_W-1]};
        dv_ge    = dv_shift >= {1'b0, dvr_reg};
    end

    logic signed [PROD_W:0] num_sum;
    assign num_sum = PROD_W'(p0_reg) + PROD_W'(p1_reg);

    // saturated inputs
    logic [FX_W-1:0]          fx_sat;
    logic signed [FY_W-1:0]   fy_sat;
    always_comb begin
        fx_sat = (32'(in_freq_x) > HALF_SIZE - 1) ? FX_W'(HALF_SIZE - 1) : in_freq_x;
        if (32'(signed'(in_freq_y)) > HALF_SIZE - 1) begin
            fy_sat = FY_W'(HALF_SIZE - 1);
        end else if (32'(signed'(in_freq_y)) < -HALF_SIZE) begin
            fy_sat = FY_W'(-HALF_SIZE);
        end else begin
            fy_sat = in_freq_y;
        end
    end

    // walk helpers on the entry just read
    logic [CNT_W-1:0] walk_last;
    assign walk_last = n_eff - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            s_ready_reg   <= 1'b1;
            m_valid_reg   <= 1'b0;
            raddr_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_ready_reg) begin
                        s_ready_reg <= 1'b0;
                        if (s_tuser == KIND_LOAD) begin
                            wout_reg    <= '0;
                            r_reg       <= '0;
                            stat_reg    <= ST_LOAD;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else begin
                            fx_reg    <= fx_sat;
                            my_reg    <= fy_sat[FY_W-1] ? FY_W'(-fy_sat) : fy_sat;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    ax_reg    <= AX_W'(fx_reg) * AX_W'(inv_x_reg);
                    ay_reg    <= AX_W'(my_reg) * AX_W'(inv_y_reg);
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    // 26-bit squares; a larger axis saturates the radius
                    sat_reg   <= (ax_reg[AX_W-1:26] != '0) || (ay_reg[AX_W-1:26] != '0);
                    rem_reg   <= SUM_W'(ax_reg[25:0]) * SUM_W'(ax_reg[25:0])
                                 + SUM_W'(ay_reg[25:0]) * SUM_W'(ay_reg[25:0]);
                    root_reg  <= '0;
                    rcnt_reg  <= RCNT_W'(ROOT_W);
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    // one root bit a cycle, most significant first
                    if (rt_ge) begin
                        rem_reg  <= rem_reg - rt_trial;
                        root_reg <= root_reg | (ROOT_W'(1) << (rcnt_reg - RCNT_W'(1)));
                    end
                    rcnt_reg <= rcnt_reg - RCNT_W'(1);
                    if (rcnt_reg == RCNT_W'(1)) begin
                        state_reg     <= S_WALK;
                        raddr_cnt_reg <= '0;
                        idx_reg       <= '0;
                        bad_reg       <= 1'b0;
                        hit_reg       <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (idx_reg == '0 && raddr_cnt_reg == '0) begin
                        // first cycle: finalize radius and start reads
                        if (sat_reg || (root_reg >> 8) > ROOT_W'(RADIUS_MAX)) begin
                            r_reg <= RADIUS_MAX;
                        end else begin
                            r_reg <= root_reg[RADIUS_W+7:8];
                        end
                        raddr_cnt_reg <= CNT_W'(1);
                    end else begin
                        if (raddr_cnt_reg < n_eff) begin
                            raddr_cnt_reg <= raddr_cnt_reg + CNT_W'(1);
                        end
                        // entry idx_reg is on ram_rdata
                        prev_r_reg <= rd_r;
                        prev_w_reg <= rd_w;
                        if (idx_reg == '0) begin
                            first_r_reg <= rd_r;
                        end else begin
                            if (rd_r < prev_r_reg) begin
                                bad_reg <= 1'b1;
                            end
                            if (prev_r_reg <= r_reg && r_reg <= rd_r) begin
                                hit_reg <= 1'b1;
                                r0_reg  <= prev_r_reg;
                                r1_reg  <= rd_r;
                                w0_reg  <= prev_w_reg;
                                w1_reg  <= rd_w;
                            end
                        end
                        if (idx_reg == walk_last) begin
                            last_r_reg <= rd_r;
                            last_w_reg <= rd_w;
                            state_reg  <= S_INTP;
                        end
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_INTP: begin
                    p0_reg   <= PROD_W'(w0_reg) * signed'(PROD_W'({1'b0, r1_reg - r_reg}));
                    p1_reg   <= PROD_W'(w1_reg) * signed'(PROD_W'({1'b0, r_reg - r0_reg}));
                    dvr_reg  <= DIFF_W'(r1_reg - r0_reg);
                    if (bad_reg) begin
                        wout_reg    <= '0;
                        stat_reg    <= ST_BAD;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else if (r_reg < first_r_reg) begin
                        wout_reg    <= '0;
                        stat_reg    <= ST_VALID;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else if (r_reg >= last_r_reg || !hit_reg) begin
                        wout_reg    <= last_w_reg;
                        stat_reg    <= ST_VALID;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else if (r1_reg == r0_reg) begin
                        wout_reg    <= w1_reg;
                        stat_reg    <= ST_VALID;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        state_reg <= S_MULW;
                    end
                end
                S_MULW: begin
                    neg_reg   <= num_sum[PROD_W];
                    num_reg   <= num_sum[PROD_W] ? NUM_W'(-num_sum) : NUM_W'(num_sum);
                    drem_reg  <= '0;
                    dcnt_reg  <= DCNT_W'(NUM_W);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    drem_reg <= dv_ge ? dv_shift - {1'b0, dvr_reg} : dv_shift;
                    num_reg  <= {num_reg[NUM_W-2:0], dv_ge};
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1)) begin
                        wout_reg <= neg_reg
                            ? WEIGHT_W'(-{num_reg[NUM_W-2:0], dv_ge})
                            : WEIGHT_W'({num_reg[NUM_W-2:0], dv_ge});
                        stat_reg    <= ST_VALID;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = s_ready_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({stat_reg, r_reg, wout_reg});

    // ---------------- assertions
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> idx_reg < n_eff)
        else $error("table walk beyond point count");

    a_load_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_LOAD |=> m_tvalid && stat_reg == ST_LOAD)
        else $error("load result missing");

endmodule
